// ===== src/wmt_pkg.sv =====
package wmt_pkg;

    localparam int SAMPLE_WIDTH    = 32;
    localparam int COUNT_WIDTH     = 16;
    localparam int DIVISOR_WIDTH   = COUNT_WIDTH + 1;
    localparam int NUM_WIDTH       = SAMPLE_WIDTH + COUNT_WIDTH + 1;
    localparam int STEP_WIDTH      = $clog2(SAMPLE_WIDTH);
    localparam int MODE_WIDTH      = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [MODE_WIDTH-1:0] MODE_MEAN = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_MIN  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_MAX  = 2'd2;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STAT_MODE   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COUNT_LIMIT = 2'd1;

    localparam logic signed [SAMPLE_WIDTH-1:0] STAT_MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] STAT_MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                           kind;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] stat_value;
        logic                           is_valid;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } wmt_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic prep;
        logic div_step;
        logic commit;
    } wmt_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } wmt_status_t;

    // starting value of the statistic; unused mode keeps what it has
    function automatic logic signed [SAMPLE_WIDTH-1:0] init_value(
        input logic [MODE_WIDTH-1:0]    mode,
        input logic signed [SAMPLE_WIDTH-1:0] current
    );
        logic signed [SAMPLE_WIDTH-1:0] value;
        unique case (mode)
            MODE_MEAN: value = '0;
            MODE_MIN:  value = STAT_MOST_POS;
            MODE_MAX:  value = STAT_MOST_NEG;
            default:   value = current;
        endcase
        return value;
    endfunction

endpackage

// ===== src/wmt_ctrl.sv =====
module wmt_ctrl import wmt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  wmt_status_t status,
    output wmt_cmd_t    cmd
);

    wmt_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = status.need_div ? ST_PREP : ST_DONE;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait until the output register is free
                if (!out_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== src/wmt_datapath.sv =====
module wmt_datapath import wmt_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  wmt_cmd_t                   cmd,
    output wmt_status_t                status,
    input  in_item_t                   s_item,
    input  logic                       cfg_valid,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output out_item_t                  m_item
);

    logic [MODE_WIDTH-1:0]          mode_reg;
    logic [COUNT_WIDTH-1:0]         limit_reg;
    logic signed [SAMPLE_WIDTH-1:0] stat_reg, stat_next;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;

    logic                           kind_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [DIVISOR_WIDTH-1:0]       divisor_reg;
    logic signed [NUM_WIDTH-1:0]    num_reg, num_next;
    logic [NUM_WIDTH-1:0]           num_mag;
    logic                           neg_reg;
    logic [DIVISOR_WIDTH-1:0]       rem_reg;
    logic [SAMPLE_WIDTH-1:0]        quo_reg;
    logic [STEP_WIDTH-1:0]          step_reg;
    out_item_t                      out_reg;

    logic [DIVISOR_WIDTH:0]         shifted, trial;
    logic                           fits;
    logic signed [SAMPLE_WIDTH-1:0] div_result;

    // stat*count + sample, kept wide enough for the worst-case product
    assign num_next = stat_reg * $signed({1'b0, count_reg}) + NUM_WIDTH'(sample_reg);
    assign num_mag  = num_reg[NUM_WIDTH-1] ? NUM_WIDTH'(-num_reg) : NUM_WIDTH'(num_reg);

    // restoring divide step; remainder stays below the divisor
    assign shifted = {rem_reg, quo_reg[SAMPLE_WIDTH-1]};
    assign trial   = shifted - {1'b0, divisor_reg};
    assign fits    = shifted >= {1'b0, divisor_reg};

    assign div_result = neg_reg ? SAMPLE_WIDTH'(-quo_reg) : SAMPLE_WIDTH'(quo_reg);

    assign status.need_div = (kind_reg == KIND_ADD) && (mode_reg == MODE_MEAN);
    assign status.div_last = step_reg == '0;

    always_comb begin
        stat_next  = stat_reg;
        count_next = count_reg;
        if (kind_reg == KIND_CLEAR) begin
            stat_next  = init_value(mode_reg, stat_reg);
            count_next = '0;
        end else begin
            unique case (mode_reg)
                MODE_MEAN: stat_next = div_result;
                MODE_MIN:  stat_next = (sample_reg < stat_reg) ? sample_reg : stat_reg;
                MODE_MAX:  stat_next = (sample_reg > stat_reg) ? sample_reg : stat_reg;
                default:   stat_next = stat_reg;
            endcase
            if (count_reg < limit_reg) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_MEAN;
            limit_reg <= '0;
            stat_reg  <= '0;
            count_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STAT_MODE: begin
                    mode_reg  <= cfg_data[MODE_WIDTH-1:0];
                    stat_reg  <= init_value(cfg_data[MODE_WIDTH-1:0], stat_reg);
                    count_reg <= '0;
                end
                CFG_COUNT_LIMIT: begin
                    limit_reg <= cfg_data[COUNT_WIDTH-1:0];
                    stat_reg  <= init_value(mode_reg, stat_reg);
                    count_reg <= '0;
                end
                default: ;
            endcase
        end else if (cmd.commit) begin
            stat_reg  <= stat_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= s_item.kind;
            sample_reg  <= s_item.sample;
            divisor_reg <= {1'b0, count_reg} + 1'b1;
        end
        if (cmd.mul) begin
            num_reg <= num_next;
        end
        if (cmd.prep) begin
            neg_reg  <= num_reg[NUM_WIDTH-1];
            rem_reg  <= num_mag[NUM_WIDTH-1:SAMPLE_WIDTH];
            quo_reg  <= num_mag[SAMPLE_WIDTH-1:0];
            step_reg <= STEP_WIDTH'(SAMPLE_WIDTH - 1);
        end
        if (cmd.div_step) begin
            rem_reg  <= fits ? trial[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
            quo_reg  <= {quo_reg[SAMPLE_WIDTH-2:0], fits};
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.commit) begin
            out_reg.stat_value <= stat_next;
            out_reg.is_valid   <= count_next != '0;
        end
    end

    assign m_item = out_reg;

endmodule

// ===== src/windowed_mean_min_max_tracker.sv =====
// Running mean / minimum / maximum of signed Q16.16 samples.
// Input channel s_valid/s_ready/s_item carries one request: kind add or clear,
// and a sample. Every request yields exactly one result on m_valid/m_ready/m_item:
// the statistic after the request and is_valid (sample count above zero).
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 stat_mode
// (0 mean, 1 min, 2 max), index 1 count_limit. cfg_ready is always high; a write
// to either register restarts the statistic and zeroes the count.
// Mean requests pass through a multiply state, a setup state and a radix-2
// restoring divider of SAMPLE_WIDTH steps before the done state. Min, max and
// clear requests go from the multiply state straight to the done state. A new
// request is taken only when the controller is back in idle, after the last
// result is committed. The divider sets the pace.
// Results land in an output register, so the next request is taken while a
// result waits; if the receiver stalls longer, the finished request holds in the
// controller until the output register is taken.
// Reset (aresetn low, synchronous): mode mean, count_limit 0, statistic 0,
// count 0, no result pending.
module windowed_mean_min_max_tracker import wmt_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output out_item_t                  m_item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    wmt_cmd_t    cmd;
    wmt_status_t status;

    assign cfg_ready = 1'b1;

    wmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wmt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_item    (s_item),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_item    (m_item)
    );

    // a result never overwrites one the receiver has not taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("result committed over a pending output");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in progress");

    // the controller issues at most one command per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

    // a commit always raises the output valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("commit without output valid");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import wmt_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int TAIL_CYCLES    = 60;
    localparam int CALM_TAIL      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 500;

    localparam logic [MODE_WIDTH-1:0]      MODE_UNUSED  = 2'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_B = 2'd3;

    typedef enum logic [1:0] {
        OP_REQ,
        OP_CFG,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t                    kind;
        in_item_t                    req;
        logic [CFG_INDEX_WIDTH-1:0]  idx;
        logic [CFG_DATA_WIDTH-1:0]   data;
    } op_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    in_item_t                   s_item    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    out_item_t                  m_item;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    op_t       pending_ops[$];
    out_item_t expected_stats[$];

    // tracker state as the block should hold it
    logic [MODE_WIDTH-1:0]          trk_mode;
    logic [CFG_DATA_WIDTH-1:0]      trk_limit;
    logic [COUNT_WIDTH-1:0]         trk_count;
    logic signed [SAMPLE_WIDTH-1:0] trk_stat;

    logic drv_nv;
    logic drv_nc;
    logic just_gapped;
    logic calm = 1'b0;
    int   gap_cnt;
    int   quiet_cnt;
    int   stall_cnt;
    int   idle_cycles;
    op_t  cur;

    int errors    = 0;
    int n_reqs    = 0;
    int n_clears  = 0;
    int n_writes  = 0;
    int n_results = 0;
    int mode_reqs[4] = '{0, 0, 0, 0};

    windowed_mean_min_max_tracker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic void restart_stat();
        trk_count = '0;
        case (trk_mode)
            MODE_MEAN: trk_stat = '0;
            MODE_MIN:  trk_stat = STAT_MOST_POS;
            MODE_MAX:  trk_stat = STAT_MOST_NEG;
            default:   ;  // unused mode holds the statistic
        endcase
    endfunction

    function automatic out_item_t next_stat(input in_item_t req);
        out_item_t res;
        longint    num;
        longint    quo;
        logic signed [SAMPLE_WIDTH-1:0] smp;
        smp = $signed(req.sample);
        if (req.kind == KIND_CLEAR) begin
            restart_stat();
        end else begin
            case (trk_mode)
                MODE_MEAN: begin
                    num = longint'(trk_stat) * longint'(trk_count) + longint'(smp);
                    quo = num / (longint'(trk_count) + 64'sd1);
                    trk_stat = quo[SAMPLE_WIDTH-1:0];
                end
                MODE_MIN: if (smp < trk_stat) trk_stat = smp;
                MODE_MAX: if (smp > trk_stat) trk_stat = smp;
                default:  ;
            endcase
            if (trk_count < trk_limit) trk_count = trk_count + 1'b1;
        end
        res.stat_value = trk_stat;
        res.is_valid   = (trk_count != '0);
        return res;
    endfunction

    task automatic queue_request(input logic kind, input logic [SAMPLE_WIDTH-1:0] sample);
        op_t op;
        op.kind       = OP_REQ;
        op.req.kind   = kind;
        op.req.sample = sample;
        op.idx        = '0;
        op.data       = '0;
        pending_ops.push_back(op);
    endtask

    task automatic queue_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                               input logic [CFG_DATA_WIDTH-1:0] data);
        op_t op;
        op.kind = OP_CFG;
        op.req  = '0;
        op.idx  = idx;
        op.data = data;
        pending_ops.push_back(op);
    endtask

    task automatic queue_drain();
        op_t op;
        op.kind = OP_DRAIN;
        op.req  = '0;
        op.idx  = '0;
        op.data = '0;
        pending_ops.push_back(op);
    endtask

    // request and config driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            cfg_valid   <= 1'b0;
            calm        <= 1'b0;
            gap_cnt     = 0;
            quiet_cnt   = 0;
            just_gapped = 1'b0;
            trk_mode    = MODE_MEAN;
            trk_limit   = '0;
            trk_count   = '0;
            trk_stat    = '0;
        end else begin
            drv_nv = s_valid;
            drv_nc = cfg_valid;
            if (s_valid && s_ready) begin
                n_reqs++;
                mode_reqs[trk_mode]++;
                if (s_item.kind == KIND_CLEAR) n_clears++;
                expected_stats.push_back(next_stat(s_item));
                drv_nv = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                n_writes++;
                case (cfg_index)
                    CFG_STAT_MODE: begin
                        trk_mode = cfg_data[MODE_WIDTH-1:0];
                        restart_stat();
                    end
                    CFG_COUNT_LIMIT: begin
                        trk_limit = cfg_data;
                        restart_stat();
                    end
                    default: ;
                endcase
                drv_nc = 1'b0;
            end
            if (expected_stats.size() == 0 && !drv_nv && !drv_nc) quiet_cnt++;
            else quiet_cnt = 0;
            if (!drv_nv && !drv_nc && pending_ops.size() != 0) begin
                cur = pending_ops[0];
                if (cur.kind == OP_REQ) begin
                    if (gap_cnt > 0) begin
                        gap_cnt--;
                    end else if (!calm && !just_gapped && $urandom_range(0, 3) == 0) begin
                        gap_cnt     = $urandom_range(0, 3);
                        just_gapped = 1'b1;
                    end else begin
                        void'(pending_ops.pop_front());
                        s_item      <= cur.req;
                        drv_nv      = 1'b1;
                        just_gapped = 1'b0;
                    end
                end else if (quiet_cnt >= SETTLE_CYCLES) begin
                    // config writes and drains only once the block is idle
                    void'(pending_ops.pop_front());
                    if (cur.kind == OP_CFG) begin
                        cfg_index <= cur.idx;
                        cfg_data  <= cur.data;
                        drv_nc    = 1'b1;
                    end
                    quiet_cnt = 0;
                end
            end
            s_valid   <= drv_nv;
            cfg_valid <= drv_nc;
            calm      <= (pending_ops.size() < CALM_TAIL);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_stats.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h/%b",
                             $time, m_item.stat_value, m_item.is_valid);
                end else begin
                    n_results++;
                    if (m_item.stat_value !== expected_stats[0].stat_value) begin
                        errors++;
                        $display("%0t: stat_value expected %h actual %h", $time,
                                 expected_stats[0].stat_value, m_item.stat_value);
                    end
                    if (m_item.is_valid !== expected_stats[0].is_valid) begin
                        errors++;
                        $display("%0t: is_valid expected %b actual %b", $time,
                                 expected_stats[0].is_valid, m_item.is_valid);
                    end
                    void'(expected_stats.pop_front());
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_cnt = $urandom_range(0, 3);
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int                             built;
        int                             nphase;
        int                             nitems;
        int                             sel;
        logic signed [SAMPLE_WIDTH-1:0] smp;
        logic [MODE_WIDTH-1:0]          md;
        logic [13:0]                    pad;
        logic [CFG_DATA_WIDTH-1:0]      lim;

        // reset setup: mean with count_limit 0, so the count stays at zero and the mean follows each sample
        queue_request(KIND_ADD, STAT_MOST_POS);
        queue_request(KIND_ADD, STAT_MOST_NEG);
        queue_request(KIND_ADD, -32'sd1);
        queue_request(KIND_CLEAR, 32'h5A5A_A5A5);
        queue_request(KIND_ADD, 32'sd1);
        queue_write(CFG_COUNT_LIMIT, 16'hFFFF);
        queue_request(KIND_ADD, STAT_MOST_POS);
        queue_request(KIND_ADD, STAT_MOST_POS);
        queue_request(KIND_ADD, STAT_MOST_NEG);
        queue_request(KIND_ADD, 32'sd3);
        queue_request(KIND_ADD, -32'sd7);  // negative sample; the quotient stays positive and truncates toward zero
        queue_request(KIND_CLEAR, STAT_MOST_NEG);
        queue_request(KIND_ADD, 32'sd5);
        queue_write(CFG_STAT_MODE, {14'd0, MODE_MIN});
        queue_request(KIND_ADD, 32'sd0);
        queue_request(KIND_ADD, STAT_MOST_POS);
        queue_request(KIND_ADD, STAT_MOST_NEG);
        queue_request(KIND_ADD, 32'sd5);
        queue_request(KIND_CLEAR, 32'sd0);
        queue_write(CFG_STAT_MODE, {14'd0, MODE_MAX});
        queue_request(KIND_ADD, STAT_MOST_NEG);
        queue_request(KIND_ADD, -32'sd3);
        queue_request(KIND_ADD, STAT_MOST_POS);
        queue_request(KIND_CLEAR, 32'sd0);
        // unused mode keeps the statistic, out-of-range indexes change nothing
        queue_write(CFG_STAT_MODE, {14'd0, MODE_UNUSED});
        queue_request(KIND_ADD, 32'sd9);
        queue_request(KIND_CLEAR, 32'sd0);
        queue_request(KIND_ADD, -32'sd1);
        queue_write(CFG_UNUSED_A, 16'hFFFF);
        queue_write(CFG_UNUSED_B, 16'h0000);
        queue_request(KIND_ADD, 32'sd4);

        built  = 0;
        nphase = 0;
        while (built < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 10);
            md  = (sel < 4) ? MODE_MEAN : (sel < 7) ? MODE_MIN :
                  (sel < 10) ? MODE_MAX : MODE_UNUSED;
            pad = 14'($urandom);
            sel = $urandom_range(0, 7);
            lim = (sel == 0) ? 16'd0 : (sel == 1) ? 16'd1 : (sel == 2) ? 16'hFFFF :
                  (sel == 3) ? 16'($urandom) : 16'($urandom_range(2, 12));
            if ($urandom_range(0, 1) == 0) begin
                queue_write(CFG_STAT_MODE, {pad, md});
                queue_write(CFG_COUNT_LIMIT, lim);
            end else begin
                queue_write(CFG_COUNT_LIMIT, lim);
                queue_write(CFG_STAT_MODE, {pad, md});
            end
            if ($urandom_range(0, 5) == 0)
                queue_write(($urandom_range(0, 1) == 0) ? CFG_UNUSED_A : CFG_UNUSED_B,
                            16'($urandom));
            nitems = $urandom_range(15, 45);
            for (int i = 0; i < nitems; i++) begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       smp = STAT_MOST_POS;
                    1:       smp = STAT_MOST_NEG;
                    2, 3:    smp = $urandom_range(0, 511) - 256;
                    4:       smp = $urandom_range(0, 262143) - 131072;
                    default: smp = $urandom;
                endcase
                queue_request(($urandom_range(0, 19) == 0) ? KIND_CLEAR : KIND_ADD, smp);
                // hold the sender until every outstanding result is back
                if ((nphase == 1 && i == nitems / 2) || $urandom_range(0, 49) == 0)
                    queue_drain();
                built++;
            end
            nphase++;
        end

        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (pending_ops.size() != 0 || s_valid || cfg_valid || expected_stats.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d requests (%0d clears) around %0d config writes; %0d results checked",
                 n_reqs, n_clears, n_writes, n_results);
        $display("requests by mode: mean %0d, min %0d, max %0d, unused %0d; %0d errors",
                 mode_reqs[0], mode_reqs[1], mode_reqs[2], mode_reqs[3], errors);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/wmt_pkg.sv
src/wmt_ctrl.sv
src/wmt_datapath.sv
src/windowed_mean_min_max_tracker.sv
tb/tb_top.sv
